/* hw/rtl/irtd_pkg.sv */
// shared types and constants for the interleaved rtp/tcp deframer
package irtd_pkg;

	localparam int unsigned HDR_LEN         = 12;
	localparam int unsigned FIFO_DEPTH_DFLT = 4;
	localparam logic [6:0]  STRIP_PT_RST    = 7'd96;
	localparam logic [7:0]  START_BYTE      = 8'h24;
	localparam logic [7:0]  CHAN_RTP        = 8'd0;
	localparam logic [7:0]  CHAN_RTCP       = 8'd1;

	typedef enum logic [2:0] {
		PH_DOLLAR  = 3'd0,
		PH_CHANNEL = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_BODY    = 3'd4
	} phase_t;

	// one queue entry: a single beat, or the held byte 0 followed by byte 1
	typedef struct packed {
		logic       pair;
		logic [7:0] held;
		logic [7:0] data;
		logic       last;
		logic       hdr;
	} cmd_t;

endpackage

/* hw/rtl/irtd_front.sv */
// frame parser: tracks framing state and queues the beats each byte produces
module irtd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  logic              chunk_end,
	input  logic              cfg_wr_en,
	input  logic [6:0]        cfg_wr_data,
	input  logic              q_full,
	output logic              q_push,
	output irtd_pkg::cmd_t    q_cmd
);
	import irtd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [15:0] len_q, len_n;
	logic [15:0] pos_q, pos_n;
	logic [7:0]  held_q, held_n;
	logic        rtcp_q, rtcp_n;
	logic        strip_q, strip_n;
	logic        drop_q, drop_n;
	logic [6:0]  strip_pt_q;
	logic        accept;
	logic        last;
	logic        push;
	cmd_t        cmd;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign last     = ({1'b0, pos_q} + 17'd1) == {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_pt_q <= STRIP_PT_RST;
		end else if (cfg_wr_en) begin
			strip_pt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DOLLAR;
			len_q   <= '0;
			pos_q   <= '0;
			held_q  <= '0;
			rtcp_q  <= 1'b0;
			strip_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			held_q  <= held_n;
			rtcp_q  <= rtcp_n;
			strip_q <= strip_n;
			drop_q  <= drop_n;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		len_n    = len_q;
		pos_n    = pos_q;
		held_n   = held_q;
		rtcp_n   = rtcp_q;
		strip_n  = strip_q;
		drop_n   = drop_q;
		push     = 1'b0;
		cmd.pair = 1'b0;
		cmd.held = held_q;
		cmd.data = rx_byte;
		cmd.last = last;
		cmd.hdr  = 1'b0;
		if (drop_q) begin
			if (chunk_end) begin
				drop_n  = 1'b0;
				phase_n = PH_DOLLAR;
				pos_n   = '0;
				strip_n = 1'b0;
				rtcp_n  = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_CHANNEL: begin
					if (rx_byte == CHAN_RTP || rx_byte == CHAN_RTCP) begin
						rtcp_n  = (rx_byte == CHAN_RTCP);
						phase_n = PH_LEN_HI;
					end else begin
						phase_n = PH_DOLLAR;
						pos_n   = '0;
						strip_n = 1'b0;
						rtcp_n  = 1'b0;
						drop_n  = !chunk_end;
					end
				end
				PH_LEN_HI: begin
					len_n   = {rx_byte, 8'h00};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_n   = {len_q[15:8], rx_byte};
					pos_n   = '0;
					strip_n = 1'b0;
					if (len_n == 16'd0) begin
						phase_n = PH_DOLLAR;
						rtcp_n  = 1'b0;
					end else begin
						phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					if (!rtcp_q) begin
						if (pos_q == 16'd0) begin
							if (last) begin
								push = 1'b1;
							end else begin
								held_n = rx_byte;
							end
						end else if (pos_q == 16'd1) begin
							if (len_q >= 16'(HDR_LEN) && rx_byte[6:0] == strip_pt_q) begin
								strip_n = 1'b1;
							end else begin
								push     = 1'b1;
								cmd.pair = 1'b1;
							end
						end else if (!(strip_q && pos_q < 16'(HDR_LEN))) begin
							push    = 1'b1;
							cmd.hdr = strip_q;
						end
					end
					if (last) begin
						phase_n = PH_DOLLAR;
						pos_n   = '0;
						strip_n = 1'b0;
						rtcp_n  = 1'b0;
					end else begin
						pos_n = pos_q + 16'd1;
					end
				end
				default: begin
					if (rx_byte == START_BYTE) begin
						phase_n = PH_CHANNEL;
					end else begin
						phase_n = PH_DOLLAR;
						pos_n   = '0;
						strip_n = 1'b0;
						rtcp_n  = 1'b0;
						drop_n  = !chunk_end;
					end
				end
			endcase
		end
	end

	assign q_push = accept && push;
	assign q_cmd  = cmd;

endmodule

/* hw/rtl/irtd_fifo.sv */
// short command queue between parser and output stage
module irtd_fifo #(
	parameter int unsigned DEPTH = irtd_pkg::FIFO_DEPTH_DFLT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  irtd_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output irtd_pkg::cmd_t rd_cmd,
	output logic           empty
);
	import irtd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/irtd_back.sv */
// output stage: expands queued commands into beats behind an output register
module irtd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  irtd_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           frame_last,
	output logic           header_removed
);
	import irtd_pkg::*;

	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_hdr_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       pend_last_q;
	logic       load;

	assign load  = !out_vld_q || !out_stall;
	// second beat of a pair goes out before the next command is taken
	assign q_pop = load && !pend_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			pend_q    <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_vld_q <= 1'b1;
				pend_q    <= 1'b0;
			end else if (!q_empty) begin
				out_vld_q <= 1'b1;
				pend_q    <= q_cmd.pair;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_byte_q <= pend_byte_q;
				out_last_q <= pend_last_q;
				out_hdr_q  <= 1'b0;
			end else if (!q_empty) begin
				if (q_cmd.pair) begin
					out_byte_q  <= q_cmd.held;
					out_last_q  <= 1'b0;
					out_hdr_q   <= 1'b0;
					pend_byte_q <= q_cmd.data;
					pend_last_q <= q_cmd.last;
				end else begin
					out_byte_q <= q_cmd.data;
					out_last_q <= q_cmd.last;
					out_hdr_q  <= q_cmd.hdr;
				end
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign out_byte       = out_byte_q;
	assign frame_last     = out_last_q;
	assign header_removed = out_hdr_q;

endmodule

/* hw/rtl/interleaved_rtp_tcp_deframer.sv */
// top level of the interleaved rtp/tcp deframer
// Takes one stream byte per cycle and emits channel 0 frame bodies as byte beats, the
// final beat of a frame flagged, optionally with the 12-byte rtp header removed when the
// payload type matches the value written by cfg_wr_data (96 at reset) and the frame holds
// at least 12 bytes. A parser classifies each byte combinationally and pushes at most one
// command into a small queue; the output stage turns each command into one or two beats
// (byte 1 of an unstripped frame releases the held byte 0 as well). An emitted beat passes
// through the queue and then the output register. Input is accepted every cycle while the
// queue has room, and a full queue stalls input even in a cycle it is popped; the output
// stage sends one beat per cycle, so out_stall, plus one extra beat for each unstripped
// channel 0 frame of two or more bytes, is what backs up into in_stall.
module interleaved_rtp_tcp_deframer #(
	parameter int unsigned FIFO_DEPTH = irtd_pkg::FIFO_DEPTH_DFLT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       chunk_end,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       frame_last,
	output logic       header_removed
);
	import irtd_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	irtd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.chunk_end   (chunk_end),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (wr_cmd)
	);

	irtd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (rd_cmd),
		.empty  (q_empty)
	);

	irtd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_cmd          (rd_cmd),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.frame_last     (frame_last),
		.header_removed (header_removed)
	);

endmodule
